// File: rtl/chu_pkg.sv
// Shared widths, codes and divider settings for the chained hash table unit.
`timescale 1ns / 1ps

package chu_pkg;

	localparam int KEY_W    = 31;
	localparam int PAY_W    = 16;
	localparam int CFG_W    = 9;
	localparam int STAT_W   = 2;
	localparam int DIV_BITS = 4;
	localparam int DIV_STEPS = 8;
	localparam logic [CFG_W-1:0] BUCKETS_RESET = CFG_W'(179);

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

endpackage

// File: rtl/chu_mod_unit.sv
// Iterative key modulo unit: several remainder bits per cycle by compare and subtract.
`timescale 1ns / 1ps

module chu_mod_unit #(
	parameter int MOD_W = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [chu_pkg::KEY_W-1:0] key,
	input  logic [MOD_W-1:0]         modulus,
	output logic                     done,
	output logic [MOD_W-1:0]         remainder
);
	import chu_pkg::*;

	localparam int DVD_W = DIV_BITS * DIV_STEPS;
	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	logic [DVD_W-1:0] dvd_q;
	logic [MOD_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MOD_W-1:0] rem_nxt;
	logic [MOD_W:0]   trial;

	always_comb begin
		rem_nxt = rem_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {rem_nxt, dvd_q[DVD_W-1-i]};
			if (trial >= {1'b0, modulus}) begin
				trial = trial - {1'b0, modulus};
			end
			rem_nxt = trial[MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DVD_W'(key);
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIV_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// File: rtl/chained_hash_table_unit.sv
// Top level of the chained hash table: sequencer, bucket heads and node pool.
// An accepted transaction passes through the key modulo unit, a head read and a head check
// before its result is ready; a search that misses at the head and has a chain then visits
// its chain nodes one at a time, and each node costs one pool read and one compare.
// One transaction is in work at a time; the next is taken after the result is handed
// to the output register and the sequencer has returned to idle.
// Reset clears all bucket valid bits and the pool fill count.
`timescale 1ns / 1ps

module chained_hash_table_unit #(
	parameter int MAX_BUCKETS = 256,
	parameter int POOL_NODES  = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [chu_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [chu_pkg::KEY_W-1:0]  item_key,
	input  logic [chu_pkg::PAY_W-1:0]  item_payload,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [chu_pkg::STAT_W-1:0] status,
	output logic [chu_pkg::PAY_W-1:0]  found_payload
);
	import chu_pkg::*;

	localparam int MOD_W = $clog2(MAX_BUCKETS + 1);
	localparam int BKT_W = $clog2(MAX_BUCKETS);
	localparam int IDX_W = $clog2(POOL_NODES);
	localparam int LNK_W = $clog2(POOL_NODES + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_HRD  = 7'b0000100,
		S_HCHK = 7'b0001000,
		S_PRD  = 7'b0010000,
		S_PCHK = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [LNK_W-1:0] next;
		logic [LNK_W-1:0] tail;
	} head_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} node_t;

	head_t            head_mem [MAX_BUCKETS];
	node_t            pool_mem [POOL_NODES];
	logic [LNK_W-1:0] next_mem [POOL_NODES];

	state_t             state_q;
	logic [CFG_W-1:0]   bucket_count_q;
	logic [MAX_BUCKETS-1:0] head_valid_q;
	logic [LNK_W-1:0]   fill_q;
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [PAY_W-1:0]   pay_q;
	logic [BKT_W-1:0]   bucket_q;
	logic               hv_q;
	head_t              head_rd_q;
	node_t              node_rd_q;
	logic [LNK_W-1:0]   next_rd_q;
	logic [LNK_W-1:0]   link_q;
	logic [LNK_W-1:0]   tail_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [PAY_W-1:0]   res_payload_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [PAY_W-1:0]   found_payload_q;

	logic [MOD_W-1:0]   modulus;
	logic [MOD_W-1:0]   remainder;
	logic               mod_done;
	logic               accept;
	logic               pool_full;
	logic [LNK_W-1:0]   new_link;
	logic [IDX_W-1:0]   link_idx;
	logic [IDX_W-1:0]   tail_idx;
	logic               head_we;
	head_t              head_wdata;
	logic               pool_we;
	logic               next_we;

	always_comb begin
		if (bucket_count_q == '0) begin
			modulus = MOD_W'(1);
		end else if (32'(bucket_count_q) > 32'(MAX_BUCKETS)) begin
			modulus = MOD_W'(MAX_BUCKETS);
		end else begin
			modulus = MOD_W'(bucket_count_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign pool_full = (fill_q == LNK_W'(POOL_NODES));
	assign new_link  = fill_q + LNK_W'(1);
	assign link_idx  = IDX_W'(link_q - LNK_W'(1));
	assign tail_idx  = IDX_W'(head_rd_q.tail - LNK_W'(1));

	chu_mod_unit #(
		.MOD_W(MOD_W)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.key(item_key),
		.modulus(modulus),
		.done(mod_done),
		.remainder(remainder)
	);

	// Insert decisions made on the head entry read back for the bucket.
	always_comb begin
		head_we = 1'b0;
		pool_we = 1'b0;
		next_we = 1'b0;
		head_wdata = head_rd_q;
		if (state_q == S_HCHK && op_q == REQ_INSERT) begin
			if (!hv_q) begin
				head_we = 1'b1;
				head_wdata.key = key_q;
				head_wdata.payload = pay_q;
				head_wdata.next = '0;
				head_wdata.tail = '0;
			end else if (!pool_full) begin
				pool_we = 1'b1;
				head_we = 1'b1;
				head_wdata.tail = new_link;
				if (head_rd_q.tail == '0) begin
					head_wdata.next = new_link;
				end else begin
					next_we = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[bucket_q] <= head_wdata;
		end
		head_rd_q <= head_mem[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (pool_we) begin
			pool_mem[IDX_W'(fill_q)] <= '{key: key_q, payload: pay_q};
		end
		node_rd_q <= pool_mem[link_idx];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[tail_idx] <= new_link;
		end
		next_rd_q <= next_mem[link_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bucket_count_q <= BUCKETS_RESET;
			head_valid_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bucket_count_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (head_we && !hv_q) begin
				head_valid_q[bucket_q] <= 1'b1;
			end
			if (pool_we) begin
				fill_q <= new_link;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (mod_done) begin
						state_q <= S_HRD;
					end
				end
				S_HRD: begin
					state_q <= S_HCHK;
				end
				S_HCHK: begin
					if (op_q == REQ_SEARCH && hv_q && head_rd_q.key != key_q
							&& head_rd_q.next != '0) begin
						state_q <= S_PRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (node_rd_q.key == key_q || link_q == tail_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req_type;
			key_q <= item_key;
			pay_q <= item_payload;
		end
		if (state_q == S_DIV && mod_done) begin
			bucket_q <= BKT_W'(remainder);
		end
		if (state_q == S_HRD) begin
			hv_q <= head_valid_q[bucket_q];
		end
		if (state_q == S_HCHK) begin
			link_q <= head_rd_q.next;
			tail_q <= head_rd_q.tail;
			res_payload_q <= '0;
			if (op_q == REQ_INSERT) begin
				res_status_q <= (hv_q && pool_full) ? ST_POOL_FULL : ST_OK;
			end else if (hv_q && head_rd_q.key == key_q) begin
				res_status_q <= ST_OK;
				res_payload_q <= head_rd_q.payload;
			end else begin
				res_status_q <= ST_NOT_FOUND;
			end
		end
		if (state_q == S_PCHK) begin
			link_q <= next_rd_q;
			if (node_rd_q.key == key_q) begin
				res_status_q <= ST_OK;
				res_payload_q <= node_rd_q.payload;
			end
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q <= res_status_q;
			found_payload_q <= res_payload_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_payload = found_payload_q;

endmodule
